[design/bcba_pkg.sv]
// ----------------------------------------------------------------------------
// bcba_pkg
// shared widths, command codes and types of the bitmap block allocator
// ----------------------------------------------------------------------------
package bcba_pkg;

	// defaults of the top level parameters
	localparam int NUM_BLOCKS_DEF = 1024;
	localparam int FIT_TRIES_DEF  = 2;

	// fixed field widths
	localparam int OP_W    = 3;
	localparam int SB_W    = 10;
	localparam int BCNT_W  = 11;
	localparam int LEN_W   = 23;
	localparam int BS_W    = 13;
	localparam int BIDX_W  = 10;

	// command codes
	localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
	localparam logic [OP_W-1:0] OP_MARK  = 3'd2;
	localparam logic [OP_W-1:0] OP_CHECK = 3'd3;
	localparam logic [OP_W-1:0] OP_FIND  = 3'd4;

	// block size register after reset
	localparam logic [BS_W-1:0] BS_RESET = 13'd64;

	// divider status toward the sequencer
	typedef struct packed {
		logic done;
		logic rem_nz;
	} div_stat_t;

endpackage

[design/bcba_div.sv]
// ----------------------------------------------------------------------------
// bcba_div
// restoring divider, one quotient bit per cycle, byte length by block size
// ----------------------------------------------------------------------------
module bcba_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bcba_pkg::LEN_W-1:0]   dividend,
	input  logic [bcba_pkg::BS_W-1:0]    divisor,
	output bcba_pkg::div_stat_t          stat,
	output logic [bcba_pkg::LEN_W-1:0]   quotient
);

	localparam int STEP_W = $clog2(bcba_pkg::LEN_W + 1);

	logic [bcba_pkg::BS_W-1:0]  rem_q;
	logic [bcba_pkg::BS_W-1:0]  dvs_q;
	logic [bcba_pkg::LEN_W-1:0] quo_q;
	logic [STEP_W-1:0]          step_q;
	logic                       run_q;
	logic                       done_q;
	logic [bcba_pkg::BS_W:0]    trial;
	logic                       take;
	logic [bcba_pkg::BS_W:0]    diff;

	assign trial = {rem_q, quo_q[bcba_pkg::LEN_W-1]};
	assign take  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
				rem_q  <= '0;
				dvs_q  <= divisor;
				quo_q  <= dividend;
			end else if (run_q) begin
				// remainder stays below the divisor, so it fits the divisor width
				rem_q <= take ? diff[bcba_pkg::BS_W-1:0] : trial[bcba_pkg::BS_W-1:0];
				quo_q <= {quo_q[bcba_pkg::LEN_W-2:0], take};
				if (step_q == STEP_W'(bcba_pkg::LEN_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign stat.done   = done_q;
	assign stat.rem_nz = (rem_q != '0);
	assign quotient    = quo_q;

endmodule

[design/bitmap_contiguous_block_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_contiguous_block_allocator
// used-block bitmap with a next-fit rover, one command at a time
// ----------------------------------------------------------------------------
// channel   | ports                                          | handshake
// ----------|------------------------------------------------|----------------------
// command   | op, start_block, blk_count, byte_length        | start && !busy
// result    | status, block_index                            | done, one-cycle beat
// config    | cfg_data (block size in bytes)                 | cfg_valid && cfg_ready
//
// the used map is a one-bit memory walked one block per cycle by a single
// address counter with a registered read port
// after reset the map is swept to zero, with busy high
// allocate and check walk the map, free and mark walk the run
// find: division, then per try the seek, the window walk
//   and a move to the next try
// the receiver cannot stall: each result is a single beat on done
// ----------------------------------------------------------------------------
module bitmap_contiguous_block_allocator #(
	parameter int NUM_BLOCKS = bcba_pkg::NUM_BLOCKS_DEF,
	parameter int FIT_TRIES  = bcba_pkg::FIT_TRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command
	input  logic                          start,
	output logic                          busy,
	input  logic [bcba_pkg::OP_W-1:0]     op,
	input  logic [bcba_pkg::SB_W-1:0]     start_block,
	input  logic [bcba_pkg::BCNT_W-1:0]   blk_count,
	input  logic [bcba_pkg::LEN_W-1:0]    byte_length,
	// result
	output logic                          done,
	output logic                          status,
	output logic [bcba_pkg::BIDX_W-1:0]   block_index,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bcba_pkg::BS_W-1:0]     cfg_data
);

	localparam int IDX_W  = $clog2(NUM_BLOCKS);
	localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
	localparam int RUN_W  = (CNT_W > bcba_pkg::BCNT_W) ? CNT_W : bcba_pkg::BCNT_W;
	localparam int WIDE_W = ((CNT_W > bcba_pkg::LEN_W) ? CNT_W : bcba_pkg::LEN_W) + 1;
	localparam int TRY_W  = (FIT_TRIES > 1) ? $clog2(FIT_TRIES) : 1;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

	// sequencer states
	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_ALLOC = 4'd2;
	localparam logic [3:0] ST_RUN   = 4'd3;
	localparam logic [3:0] ST_CHECK = 4'd4;
	localparam logic [3:0] ST_DIV   = 4'd5;
	localparam logic [3:0] ST_SEEK  = 4'd6;
	localparam logic [3:0] ST_WIN   = 4'd7;
	localparam logic [3:0] ST_NEXT  = 4'd8;

	logic [3:0]                   state_q;
	logic [bcba_pkg::OP_W-1:0]    op_q;
	logic [bcba_pkg::BCNT_W-1:0]  count_q;
	logic [bcba_pkg::LEN_W-1:0]   need_q;
	logic [IDX_W-1:0]             cand_q;
	logic [TRY_W-1:0]             try_q;
	logic [IDX_W-1:0]             rover_q;
	logic [bcba_pkg::BS_W-1:0]    bs_q;
	logic [CNT_W-1:0]             free_cnt_q;

	// shared walker: address counter and blocks left to visit
	logic [IDX_W-1:0]             scan_addr_q;
	logic [CNT_W-1:0]             scan_left_q;

	// used map and its registered read port
	logic                         map_q [NUM_BLOCKS];
	logic                         rd_vld_s1;
	logic [IDX_W-1:0]             rd_addr_s1;
	logic                         rd_data_s1;

	logic                         done_q;
	logic                         status_q;
	logic [bcba_pkg::BIDX_W-1:0]  block_index_q;

	logic                         accept;
	logic                         scan_st;
	logic                         issue;
	logic                         step;
	logic                         hit;
	logic                         scan_end;
	logic [IDX_W-1:0]             addr_inc;
	logic [IDX_W-1:0]             cand_inc;
	logic                         we;
	logic [IDX_W-1:0]             waddr;
	logic                         wdata;
	logic [RUN_W-1:0]             run_req;
	logic [RUN_W-1:0]             run_lim;
	logic [CNT_W-1:0]             run_len;
	logic                         too_long;
	logic                         div_start;
	bcba_pkg::div_stat_t          div_stat;
	logic [bcba_pkg::LEN_W-1:0]   div_quo;
	logic [bcba_pkg::BS_W-1:0]    divisor;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// a zero block size counts as one byte
	assign divisor   = (bs_q == '0) ? bcba_pkg::BS_W'(1) : bs_q;
	assign div_start = accept && (op == bcba_pkg::OP_FIND);

	bcba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (byte_length),
		.divisor  (divisor),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// walker control: reads go out one per cycle, data comes back through a register
	assign scan_st  = (state_q == ST_ALLOC) || (state_q == ST_CHECK) ||
	                  (state_q == ST_SEEK) || (state_q == ST_WIN);
	assign issue    = scan_st && (scan_left_q != '0);
	assign step     = issue || ((state_q == ST_RUN) && (scan_left_q != '0));
	// window walk stops on a used block, allocate and seek stop on a free one
	assign hit      = rd_vld_s1 && (rd_data_s1 == (state_q == ST_WIN)) &&
	                  ((state_q == ST_ALLOC) || (state_q == ST_SEEK) || (state_q == ST_WIN));
	assign scan_end = scan_st && !rd_vld_s1 && (scan_left_q == '0);
	assign addr_inc = (scan_addr_q == LAST_IDX) ? '0 : scan_addr_q + 1'b1;
	assign cand_inc = (rd_addr_s1 == LAST_IDX) ? '0 : rd_addr_s1 + 1'b1;

	// run length clipped at the end of the map; free of zero still clears one
	assign run_req  = ((op == bcba_pkg::OP_FREE) && (blk_count == '0)) ?
	                  RUN_W'(1) : RUN_W'(blk_count);
	assign run_lim  = (RUN_W'(start_block) >= RUN_W'(NUM_BLOCKS)) ?
	                  '0 : RUN_W'(NUM_BLOCKS) - RUN_W'(start_block);
	assign run_len  = (run_req < run_lim) ? CNT_W'(run_req) : CNT_W'(run_lim);

	assign too_long = (WIDE_W'(rd_addr_s1) + WIDE_W'(need_q)) > WIDE_W'(NUM_BLOCKS);

	// single write port of the map
	always_comb begin
		we    = 1'b0;
		waddr = scan_addr_q;
		wdata = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
			end
			ST_RUN: begin
				we    = (scan_left_q != '0);
				wdata = (op_q == bcba_pkg::OP_MARK);
			end
			ST_ALLOC: begin
				we    = hit;
				waddr = rd_addr_s1;
				wdata = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			map_q[waddr] <= wdata;
		end
		if (issue) begin
			rd_data_s1 <= map_q[scan_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			op_q          <= '0;
			count_q       <= '0;
			need_q        <= '0;
			cand_q        <= '0;
			try_q         <= '0;
			rover_q       <= '0;
			bs_q          <= bcba_pkg::BS_RESET;
			free_cnt_q    <= '0;
			scan_addr_q   <= '0;
			scan_left_q   <= '0;
			rd_vld_s1     <= 1'b0;
			rd_addr_s1    <= '0;
			done_q        <= 1'b0;
			status_q      <= 1'b0;
			block_index_q <= '0;
		end else begin
			done_q     <= 1'b0;
			rd_vld_s1  <= issue && !hit;
			rd_addr_s1 <= scan_addr_q;
			if (step) begin
				scan_addr_q <= addr_inc;
				scan_left_q <= scan_left_q - 1'b1;
			end
			if (cfg_valid) begin
				bs_q <= cfg_data;
			end

			unique case (state_q)
				ST_CLEAR: begin
					// sweep every block to free after reset
					if (scan_addr_q == LAST_IDX) begin
						scan_addr_q <= '0;
						state_q     <= ST_IDLE;
					end else begin
						scan_addr_q <= addr_inc;
					end
				end

				ST_IDLE: begin
					if (accept) begin
						op_q    <= op;
						count_q <= blk_count;
						unique case (op) inside
							bcba_pkg::OP_ALLOC: begin
								scan_addr_q <= '0;
								scan_left_q <= CNT_W'(NUM_BLOCKS);
								state_q     <= ST_ALLOC;
							end
							bcba_pkg::OP_FREE, bcba_pkg::OP_MARK: begin
								scan_addr_q <= IDX_W'(start_block);
								scan_left_q <= run_len;
								state_q     <= ST_RUN;
							end
							bcba_pkg::OP_CHECK: begin
								scan_addr_q <= '0;
								scan_left_q <= CNT_W'(NUM_BLOCKS);
								free_cnt_q  <= '0;
								state_q     <= ST_CHECK;
							end
							bcba_pkg::OP_FIND: begin
								try_q   <= '0;
								state_q <= ST_DIV;
							end
							default: begin
								// unknown command: fail at once, state untouched
								done_q        <= 1'b1;
								status_q      <= 1'b1;
								block_index_q <= '0;
							end
						endcase
					end
				end

				ST_ALLOC: begin
					if (hit) begin
						done_q        <= 1'b1;
						status_q      <= 1'b0;
						block_index_q <= bcba_pkg::BIDX_W'(rd_addr_s1);
						state_q       <= ST_IDLE;
					end else if (scan_end) begin
						done_q        <= 1'b1;
						status_q      <= 1'b1;
						block_index_q <= '0;
						state_q       <= ST_IDLE;
					end
				end

				ST_RUN: begin
					if (scan_left_q == '0) begin
						done_q        <= 1'b1;
						status_q      <= 1'b0;
						block_index_q <= '0;
						state_q       <= ST_IDLE;
					end
				end

				ST_CHECK: begin
					if (rd_vld_s1 && !rd_data_s1) begin
						free_cnt_q <= free_cnt_q + 1'b1;
					end
					if (scan_end) begin
						done_q        <= 1'b1;
						status_q      <= (RUN_W'(free_cnt_q) < RUN_W'(count_q));
						block_index_q <= '0;
						state_q       <= ST_IDLE;
					end
				end

				ST_DIV: begin
					if (div_stat.done) begin
						// ceiling of length over block size
						need_q      <= div_quo + bcba_pkg::LEN_W'(div_stat.rem_nz);
						scan_addr_q <= rover_q;
						scan_left_q <= CNT_W'(NUM_BLOCKS);
						state_q     <= ST_SEEK;
					end
				end

				ST_SEEK: begin
					if (hit) begin
						// rover moves past every candidate tried
						cand_q  <= rd_addr_s1;
						rover_q <= cand_inc;
						if (need_q == '0) begin
							done_q        <= 1'b1;
							status_q      <= 1'b0;
							block_index_q <= bcba_pkg::BIDX_W'(rd_addr_s1);
							state_q       <= ST_IDLE;
						end else if (too_long) begin
							state_q <= ST_NEXT;
						end else begin
							scan_addr_q <= rd_addr_s1;
							scan_left_q <= CNT_W'(need_q);
							state_q     <= ST_WIN;
						end
					end else if (scan_end) begin
						// map full: rover keeps its place
						done_q        <= 1'b1;
						status_q      <= 1'b1;
						block_index_q <= '0;
						state_q       <= ST_IDLE;
					end
				end

				ST_WIN: begin
					if (hit) begin
						state_q <= ST_NEXT;
					end else if (scan_end) begin
						done_q        <= 1'b1;
						status_q      <= 1'b0;
						block_index_q <= bcba_pkg::BIDX_W'(cand_q);
						state_q       <= ST_IDLE;
					end
				end

				ST_NEXT: begin
					if (try_q == TRY_W'(FIT_TRIES - 1)) begin
						done_q        <= 1'b1;
						status_q      <= 1'b1;
						block_index_q <= '0;
						state_q       <= ST_IDLE;
					end else begin
						try_q       <= try_q + 1'b1;
						scan_addr_q <= rover_q;
						scan_left_q <= CNT_W'(NUM_BLOCKS);
						state_q     <= ST_SEEK;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign block_index = block_index_q;

endmodule

[verif/bitmap_contiguous_block_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_contiguous_block_allocator_tb
// self-checking bench for the used-block bitmap allocator with next-fit rover
//
// a queue of commands feeds a clocked driver that issues them in bursts with
// random gaps; each accepted command is run through a local model of the map,
// the rover and the block size, and the reply it predicts is queued. a clocked
// monitor compares every done beat against the oldest predicted reply. the
// run is a directed part followed by random phases, each phase under its own
// block size, written while the allocator is idle
// ----------------------------------------------------------------------------
module bitmap_contiguous_block_allocator_tb;

	localparam int NB = bcba_pkg::NUM_BLOCKS_DEF;
	localparam int FT = bcba_pkg::FIT_TRIES_DEF;

	// op codes the allocator does not know, answered with status 1
	localparam logic [bcba_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [bcba_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [bcba_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

	localparam int unsigned LEN_MAX = 4194304;
	localparam int unsigned CNT_MAX = 1024;

	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 93;
	localparam int LONG_GAP_MAX    = 1200;

	// slowest find: division, then per try a full seek, a full window walk
	// and the step to the next try
	localparam int FIND_WORST = 24 + FT * (2 * NB + 5);
	localparam int ITEM_WORST = FIND_WORST + LONG_GAP_MAX + 16;
	localparam int RUN_LIMIT  = 4 * (600 * ITEM_WORST + 2 * NB + 1000);

	typedef struct packed {
		logic [bcba_pkg::OP_W-1:0]   op;
		logic [bcba_pkg::SB_W-1:0]   start_block;
		logic [bcba_pkg::BCNT_W-1:0] blk_count;
		logic [bcba_pkg::LEN_W-1:0]  byte_length;
	} cmd_t;

	typedef struct packed {
		logic                        status;
		logic [bcba_pkg::BIDX_W-1:0] block_index;
	} reply_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	// allocator ports, all known from time zero
	logic                        start       = 1'b0;
	logic                        busy;
	logic [bcba_pkg::OP_W-1:0]   op          = bcba_pkg::OP_ALLOC;
	logic [bcba_pkg::SB_W-1:0]   start_block = '0;
	logic [bcba_pkg::BCNT_W-1:0] blk_count   = '0;
	logic [bcba_pkg::LEN_W-1:0]  byte_length = '0;
	logic                        done;
	logic                        status;
	logic [bcba_pkg::BIDX_W-1:0] block_index;
	logic                        cfg_valid   = 1'b0;
	logic                        cfg_ready;
	logic [bcba_pkg::BS_W-1:0]   cfg_data    = bcba_pkg::BS_RESET;

	bitmap_contiguous_block_allocator #(
		.NUM_BLOCKS(NB),
		.FIT_TRIES (FT)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.start_block(start_block),
		.blk_count  (blk_count),
		.byte_length(byte_length),
		.done       (done),
		.status     (status),
		.block_index(block_index),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	// commands waiting to be issued and replies still owed by the allocator
	cmd_t   cmd_backlog[$];
	reply_t predicted_replies[$];

	// local copy of the allocator state
	logic [NB-1:0]             block_used = '0;
	int unsigned               rover      = 0;
	logic [bcba_pkg::BS_W-1:0] blk_bytes  = bcba_pkg::BS_RESET;

	int fail_count  = 0;
	int cycle_count = 0;

	// ------------------------------------------------------------------------
	// allocator model: applies one command to the local state, returns reply
	// ------------------------------------------------------------------------
	function automatic reply_t predict_reply(input cmd_t c);
		reply_t      r;
		int unsigned i, t, cand, got, need, bs, nfree, pos;
		bit          quit;
		r.status      = 1'b1;
		r.block_index = '0;
		quit          = 1'b0;
		case (c.op) inside
			bcba_pkg::OP_ALLOC: begin
				// lowest free block wins
				for (i = 0; i < NB && !quit; i++) begin
					if (!block_used[i]) begin
						block_used[i] = 1'b1;
						r.status      = 1'b0;
						r.block_index = i[bcba_pkg::BIDX_W-1:0];
						quit          = 1'b1;
					end
				end
			end
			bcba_pkg::OP_FREE, bcba_pkg::OP_MARK: begin
				// a free of zero blocks still clears its start block
				if (c.op == bcba_pkg::OP_FREE && c.blk_count == 0)
					block_used[c.start_block] = 1'b0;
				// blocks past the end of the map are dropped
				for (i = c.start_block; i < c.start_block + c.blk_count && i < NB; i++)
					block_used[i] = (c.op == bcba_pkg::OP_MARK);
				r.status = 1'b0;
			end
			bcba_pkg::OP_CHECK: begin
				nfree = 0;
				for (i = 0; i < NB; i++)
					if (!block_used[i])
						nfree++;
				r.status = (nfree >= c.blk_count) ? 1'b0 : 1'b1;
			end
			bcba_pkg::OP_FIND: begin
				// zero block size counts as one byte per block
				bs   = (blk_bytes == 0) ? 1 : blk_bytes;
				need = c.byte_length / bs + ((c.byte_length % bs) != 0 ? 1 : 0);
				for (t = 0; t < FT && !quit; t++) begin
					// next free block at or after the rover, wrapping
					cand = NB;
					for (i = 0; i < NB && cand == NB; i++) begin
						pos = (rover + i) % NB;
						if (!block_used[pos])
							cand = pos;
					end
					if (cand == NB) begin
						// map full, rover stays put
						quit = 1'b1;
					end else begin
						rover = (cand + 1) % NB;
						// window must be free and fit below the end of the map
						got = 0;
						for (i = cand; i < NB && i - cand < need; i++)
							if (!block_used[i])
								got++;
						if (got == need) begin
							r.status      = 1'b0;
							r.block_index = cand[bcba_pkg::BIDX_W-1:0];
							quit          = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic cmd_t make_cmd(input logic [bcba_pkg::OP_W-1:0] o,
			input int unsigned sb, input int unsigned cnt, input int unsigned len);
		cmd_t c;
		c.op          = o;
		c.start_block = sb[bcba_pkg::SB_W-1:0];
		c.blk_count   = cnt[bcba_pkg::BCNT_W-1:0];
		c.byte_length = len[bcba_pkg::LEN_W-1:0];
		return c;
	endfunction

	// random command, lengths scaled to the current block size so that
	// finds mostly ask for small windows the map can actually hold
	function automatic cmd_t random_cmd();
		cmd_t        c;
		int unsigned sel, roll, need, bs, len;
		c    = make_cmd(bcba_pkg::OP_ALLOC, $urandom_range(0, NB - 1),
			$urandom_range(0, CNT_MAX), $urandom_range(0, LEN_MAX));
		sel  = $urandom_range(0, 99);
		roll = $urandom_range(0, 99);
		if (sel < 25) begin
			c.op = bcba_pkg::OP_ALLOC;
		end else if (sel < 45) begin
			c.op = bcba_pkg::OP_FREE;
			if (roll < 70)
				c.blk_count = bcba_pkg::BCNT_W'($urandom_range(0, 16));
			else if (roll < 90)
				c.blk_count = bcba_pkg::BCNT_W'($urandom_range(0, 128));
		end else if (sel < 62) begin
			c.op = bcba_pkg::OP_MARK;
			if (roll < 75)
				c.blk_count = bcba_pkg::BCNT_W'($urandom_range(0, 8));
			else if (roll < 95)
				c.blk_count = bcba_pkg::BCNT_W'($urandom_range(0, 64));
		end else if (sel < 76) begin
			c.op = bcba_pkg::OP_CHECK;
			// counts near a full map are where the answer flips
			if (roll < 40)
				c.blk_count = bcba_pkg::BCNT_W'($urandom_range(CNT_MAX - 64, CNT_MAX));
		end else if (sel < 97) begin
			c.op = bcba_pkg::OP_FIND;
			bs   = (blk_bytes == 0) ? 1 : blk_bytes;
			if (roll < 90) begin
				need = (roll < 70) ? $urandom_range(0, 16) : $urandom_range(0, 200);
				len  = need * bs;
				// partial last block rounds up
				if ($urandom_range(0, 1) && len > 0)
					len = len - $urandom_range(0, bs - 1);
				if (len > LEN_MAX)
					len = LEN_MAX;
				c.byte_length = len[bcba_pkg::LEN_W-1:0];
			end
		end else begin
			c.op = bcba_pkg::OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
		end
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// driver: start held until accepted, bursts of commands with random gaps
	// ------------------------------------------------------------------------
	cmd_t cur_cmd;
	int   gap_left   = 0;
	int   burst_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			// command beat taken at this edge
			if (start && !busy)
				predicted_replies.push_back(predict_reply(cur_cmd));
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					cur_cmd     = cmd_backlog.pop_front();
					op          <= cur_cmd.op;
					start_block <= cur_cmd.start_block;
					blk_count   <= cur_cmd.blk_count;
					byte_length <= cur_cmd.byte_length;
					start       <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// new burst; long gaps land in the middle of a walk
						burst_left = $urandom_range(0, 15);
						case ($urandom_range(0, 9)) inside
							0:       gap_left = $urandom_range(100, LONG_GAP_MAX);
							[1:3]:   gap_left = 0;
							default: gap_left = $urandom_range(1, 5);
						endcase
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: each done beat against the oldest predicted reply
	// ------------------------------------------------------------------------
	reply_t want;

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (predicted_replies.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected reply: status %0d block_index %0d",
						status, block_index);
				fail_count++;
			end else begin
				want = predicted_replies.pop_front();
				if (status !== want.status || block_index !== want.block_index) begin
					if (fail_count < 10)
						$display("reply mismatch: status exp %0d got %0d, block_index exp %0d got %0d",
							want.status, status, want.block_index, block_index);
					fail_count++;
				end
			end
		end
	end

	// watchdog on a cycle counter
	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// sequence: reset, directed part, then random phases per block size
	// ------------------------------------------------------------------------

	// wait until every command is issued, answered and the allocator is idle;
	// also serves as the sender holding off until the map has caught up
	task automatic wait_idle();
		while (cmd_backlog.size() != 0 || start || predicted_replies.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_block_size(input logic [bcba_pkg::BS_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		// beat taken at this edge
		cfg_valid <= 1'b0;
		blk_bytes = val;
	endtask

	logic [bcba_pkg::BS_W-1:0] size_plan[PHASES];
	logic [bcba_pkg::BS_W-1:0] bs_val;
	int                        ph, n;

	initial begin
		// smallest, 4096, zero, odd, random, back to reset value
		size_plan = '{13'd1, 13'd4096, 13'd0, 13'd3, 13'd0, bcba_pkg::BS_RESET};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under the reset block size of 64 bytes
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_CHECK, 0, 0, 0));
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_CHECK, 0, CNT_MAX, 0));
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_ALLOC, NB - 1, CNT_MAX, LEN_MAX));
		// zero length needs no blocks
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_FIND, 0, 0, 0));
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_FIND, 0, 0, 193));
		// far more than the map holds
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_FIND, 0, 0, LEN_MAX));
		// run past the end of the map
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_MARK, NB - 4, 10, 0));
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_ALLOC, 0, 0, 0));
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_FREE, NB - 1, 0, 0));
		// mark of zero changes nothing
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_MARK, 5, 0, 0));
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_FREE, 0, CNT_MAX, 0));
		// full map
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_MARK, 0, CNT_MAX, 0));
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_ALLOC, 0, 0, 0));
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_FIND, 0, 0, 64));
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_CHECK, 0, 1, 0));
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_CHECK, 0, 0, 0));
		// only the last block free: two-block window runs off the end
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_FREE, NB - 1, 0, 0));
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_FIND, 0, 0, 128));
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_FIND, 0, 0, 64));
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_ALLOC, 0, 0, 0));
		cmd_backlog.push_back(make_cmd(OP_RSVD5, NB - 1, CNT_MAX, LEN_MAX));
		cmd_backlog.push_back(make_cmd(OP_RSVD6, 0, 0, 0));
		cmd_backlog.push_back(make_cmd(OP_RSVD7, NB - 1, CNT_MAX, LEN_MAX));
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_FREE, 0, CNT_MAX, 0));
		cmd_backlog.push_back(make_cmd(bcba_pkg::OP_CHECK, 0, CNT_MAX, 0));
		wait_idle();

		for (ph = 0; ph < PHASES; ph++) begin
			bs_val = (ph == 4) ? 13'($urandom_range(1, 4096)) : size_plan[ph];
			write_block_size(bs_val);
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				cmd_backlog.push_back(random_cmd());
			wait_idle();
		end

		// catch any stray done beat after the last reply
		repeat (FIND_WORST) @(posedge clk);
		if (fail_count == 0 && predicted_replies.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[bitmap_contiguous_block_allocator.f]
design/bcba_pkg.sv
design/bcba_div.sv
design/bitmap_contiguous_block_allocator.sv
verif/bitmap_contiguous_block_allocator_tb.sv
